[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker files of the frame allocator.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define BFA_ASSERT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame allocator check failed");

// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define BFA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame allocator check failed");

`endif

[rtl/core/bfa_pkg.sv]
// Shared types, constants and helpers of the bitmap frame allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package bfa_pkg;

   localparam int unsigned MAX_FRAMES_DEF  = 32768;
   localparam int unsigned FRAME_BYTES_DEF = 4096;

   localparam int unsigned FRAME_W   = 16;   // frame totals and frame numbers
   localparam int unsigned IDX_W     = 15;
   localparam int unsigned REQ_W     = 32;
   localparam int unsigned ADDR_W    = 27;
   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned BIT_W     = 5;
   localparam int unsigned WSEL_W    = FRAME_W - BIT_W;  // map word select

   localparam logic [FRAME_W-1:0] TOTAL_RESET = 16'd32768;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_FILL  = 2'd2,
      CMD_TEST  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOMEM = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic                   wr_en;
      logic [WSEL_W-1:0]      wr_word;
      logic [WORD_BITS-1:0]   wr_data;
      logic                   rd_en;
      logic [WSEL_W-1:0]      rd_word;
   } map_req_type;

   typedef struct packed {
      logic               found;
      logic [BIT_W-1:0]   bit_sel;
      logic               more;
   } scan_type;

   typedef struct packed {
      logic [FRAME_W-1:0] free_frames;
      logic               frame_was_used;
      logic [ADDR_W-1:0]  frame_address;
      logic [IDX_W-1:0]   frame_number;
      logic [1:0]         status;
   } rsp_type;

   function automatic logic [FRAME_W-1:0] free_count(input logic [FRAME_W-1:0] total,
                                                     input logic [FRAME_W-1:0] used);
      free_count = (used >= total) ? '0 : total - used;
   endfunction

endpackage

`default_nettype wire

[rtl/core/bfa_map.sv]
// Frame bitmap storage: one write port and one registered read port.
// Depends on bfa_pkg for the map request struct.
`default_nettype none

module bfa_map
   import bfa_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                 clock,
   input  wire map_req_type          map_req,
   output      logic [WORD_BITS-1:0] rd_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem[map_req.wr_word[AW-1:0]] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff <= mem[map_req.rd_word[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/bfa_scan.sv]
// Shared scan unit: limits a map word to frames below the total and finds its
// lowest clear bit; also tells whether a further word lies below the total.
// Depends on bfa_pkg.
`default_nettype none

module bfa_scan
   import bfa_pkg::*;
(
   input  wire logic [FRAME_W-1:0]   eff_total,
   input  wire logic [WSEL_W-1:0]    word_sel,
   input  wire logic [WORD_BITS-1:0] word_data,
   output      scan_type             result
);

   logic [FRAME_W:0]     rem;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] open_bits;

   always_comb begin
      rem = {1'b0, eff_total} - {1'b0, word_sel, {BIT_W{1'b0}}};
      // frames at or above the total count as used
      mask = (rem >= (FRAME_W+1)'(WORD_BITS)) ? '1
                                              : ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
      open_bits = ~word_data & mask;

      result.found   = |open_bits;
      result.more    = rem > (FRAME_W+1)'(WORD_BITS);
      result.bit_sel = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (open_bits[b]) begin
            result.bit_sel = BIT_W'(b);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/bfa_ctrl.sv]
// Sequencer of the frame allocator: command decode, map fill sweep, word scan
// through the shared scan unit, used-count upkeep and the response register.
// Depends on bfa_pkg; drives bfa_map and bfa_scan.
`default_nettype none

module bfa_ctrl
   import bfa_pkg::*;
#(
   parameter int unsigned MAX_FRAMES  = MAX_FRAMES_DEF,
   parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
   parameter int unsigned MAP_WORDS   = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [FRAME_W-1:0]   total_frames,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire cmd_type              req_command,
   input  wire logic [IDX_W-1:0]     req_frame_index,
   input  wire logic [REQ_W-1:0]     req_request_size,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      rsp_type              rsp,
   output      map_req_type          map_req,
   input  wire logic [WORD_BITS-1:0] map_rd_data,
   output      logic [FRAME_W-1:0]   eff_total,
   output      logic [WSEL_W-1:0]    scan_word,
   input  wire scan_type             scan_res
);

   typedef enum logic [2:0] {
      S_FILL, S_IDLE, S_LOOK, S_EVAL, S_CHECK, S_SCAN, S_ADDR, S_RESP
   } state_type;

   localparam logic [31:0]        MAXF      = 32'(MAX_FRAMES);
   localparam logic [WSEL_W-1:0]  LAST_WORD = WSEL_W'(MAP_WORDS - 1);
   localparam logic [ADDR_W-1:0]  FB        = ADDR_W'(FRAME_BYTES);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [REQ_W-1:0]   size_ff, size_in;
   logic [FRAME_W-1:0] used_ff, used_in;
   logic [WSEL_W-1:0]  word_ff, word_in;
   logic [WSEL_W-1:0]  fill_ff, fill_in;
   logic               silent_ff, silent_in;
   logic [FRAME_W-1:0] fnum_ff, fnum_in;
   rsp_type            rsp_ff, rsp_in;
   logic [ADDR_W-1:0]  fnum_ext;

   assign eff_total = ({16'd0, total_frames} > MAXF) ? MAXF[FRAME_W-1:0] : total_frames;
   assign scan_word = word_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp       = rsp_ff;
   assign fnum_ext  = ADDR_W'(fnum_ff);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      size_in   = size_ff;
      used_in   = used_ff;
      word_in   = word_ff;
      fill_in   = fill_ff;
      silent_in = silent_ff;
      fnum_in   = fnum_ff;
      rsp_in    = rsp_ff;
      map_req   = '0;

      case (state_ff)
         S_FILL: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_word = fill_ff;
            map_req.wr_data = '1;
            if (fill_ff == LAST_WORD) begin
               silent_in = 1'b0;
               if (silent_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_RESP;
                  rsp_in   = '{free_frames: free_count(eff_total, used_ff),
                               frame_was_used: 1'b0, frame_address: '0,
                               frame_number: '0, status: ST_OK};
               end
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_command;
               idx_in  = req_frame_index;
               size_in = req_request_size;
               case (req_command)
                  CMD_ALLOC: state_in = S_CHECK;
                  CMD_FREE, CMD_TEST: state_in = S_LOOK;
                  CMD_FILL: begin
                     state_in = S_FILL;
                     fill_in  = '0;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LOOK: begin
            if ({1'b0, idx_ff} >= eff_total) begin
               state_in = S_RESP;
               rsp_in   = '{free_frames: free_count(eff_total, used_ff),
                            frame_was_used: 1'b0, frame_address: '0,
                            frame_number: idx_ff, status: ST_RANGE};
            end else begin
               map_req.rd_en   = 1'b1;
               map_req.rd_word = WSEL_W'(idx_ff >> BIT_W);
               state_in        = S_EVAL;
            end
         end
         S_EVAL: begin
            if (cmd_ff == CMD_FREE) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_word = WSEL_W'(idx_ff >> BIT_W);
               map_req.wr_data = map_rd_data & ~(WORD_BITS'(1) << idx_ff[BIT_W-1:0]);
               used_in         = (used_ff == '0) ? '0 : used_ff - 1'b1;
            end
            state_in = S_RESP;
            rsp_in   = '{free_frames: free_count(eff_total, used_in),
                         frame_was_used: map_rd_data[idx_ff[BIT_W-1:0]],
                         frame_address: '0, frame_number: idx_ff, status: ST_OK};
         end
         S_CHECK: begin
            if ({16'd0, free_count(eff_total, used_ff)} > size_ff) begin
               map_req.rd_en   = 1'b1;
               map_req.rd_word = '0;
               word_in         = '0;
               state_in        = S_SCAN;
            end else begin
               state_in = S_RESP;
               rsp_in   = '{free_frames: free_count(eff_total, used_ff),
                            frame_was_used: 1'b0, frame_address: '0,
                            frame_number: '0, status: ST_NOMEM};
            end
         end
         S_SCAN: begin
            if (scan_res.found) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_word = word_ff;
               map_req.wr_data = map_rd_data | (WORD_BITS'(1) << scan_res.bit_sel);
               used_in         = used_ff + 1'b1;
               fnum_in         = {word_ff, scan_res.bit_sel};
               state_in        = S_ADDR;
            end else if (scan_res.more) begin
               // fetch the next word while this one is judged
               map_req.rd_en   = 1'b1;
               map_req.rd_word = word_ff + 1'b1;
               word_in         = word_ff + 1'b1;
            end else begin
               state_in = S_RESP;
               rsp_in   = '{free_frames: free_count(eff_total, used_ff),
                            frame_was_used: 1'b0, frame_address: '0,
                            frame_number: '0, status: ST_NOMEM};
            end
         end
         S_ADDR: begin
            state_in = S_RESP;
            rsp_in   = '{free_frames: free_count(eff_total, used_ff),
                         frame_was_used: 1'b0, frame_address: fnum_ext * FB,
                         frame_number: fnum_ff[IDX_W-1:0], status: ST_OK};
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_FILL;
         fill_ff   <= '0;
         silent_ff <= 1'b1;
         used_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         silent_ff <= silent_in;
         used_ff   <= used_in;
         cmd_ff    <= cmd_in;
         idx_ff    <= idx_in;
         size_ff   <= size_in;
         word_ff   <= word_in;
         fnum_ff   <= fnum_in;
         rsp_ff    <= rsp_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/bitmap_frame_allocator.sv]
// Top level of the bitmap frame allocator: configuration register, port packing
// and the sequencer, scan unit and bitmap storage. Depends on bfa_pkg,
// bfa_map, bfa_scan and bfa_ctrl.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+----------------------------------------
//   req      | in  | req_tvalid/req_tready | tuser: command; tdata: index, size
//   rsp      | out | rsp_tvalid/rsp_tready | tdata: status, frame, address, used, free
//   csr      | in  | csr_wr_en             | csr_wr_data: total_frames
//
// A successful allocate passes through check, a scan step for each map word scanned, up to
// (MAX_FRAMES+31)/32 words, paced by the single read port of the bitmap memory,
// then address and response; a refused one ends after check or the scan. Free and test
// pass through look, eval and response, and skip eval for a frame at or beyond the total.
// Mark-all-used sweeps the map one word a cycle, then gives its response.
// After reset the same sweep runs, without a response, before the first transfer is
// taken. One item is in flight at a time; a stalled response holds until rsp_tready.
`default_nettype none

module bitmap_frame_allocator
   import bfa_pkg::*;
#(
   parameter int unsigned MAX_FRAMES  = MAX_FRAMES_DEF,
   parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data,  // total_frames
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [47:0]  req_tdata,    // [14:0] frame_index, [46:15] request_size
   input  wire logic [1:0]   req_tuser,    // [1:0] command
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [63:0]  rsp_tdata     // [1:0] status, [16:2] frame_number,
                                           // [43:17] frame_address,
                                           // [44] frame_was_used, [60:45] free_frames
);

   localparam int unsigned FULL_WORDS = (MAX_FRAMES + 31) / 32;
   localparam int unsigned MAP_WORDS  = (FULL_WORDS > (1 << WSEL_W)) ? (1 << WSEL_W)
                                                                     : FULL_WORDS;

   logic [FRAME_W-1:0]   total_ff;
   logic [FRAME_W-1:0]   eff_total;
   logic [WSEL_W-1:0]    scan_word;
   logic [WORD_BITS-1:0] map_rd_data;
   map_req_type          map_req;
   scan_type             scan_res;
   rsp_type              rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
      end else if (csr_wr_en) begin
         total_ff <= csr_wr_data;
      end
   end

   bfa_ctrl #(
      .MAX_FRAMES  (MAX_FRAMES),
      .FRAME_BYTES (FRAME_BYTES),
      .MAP_WORDS   (MAP_WORDS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .total_frames     (total_ff),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_command      (cmd_type'(req_tuser)),
      .req_frame_index  (req_tdata[14:0]),
      .req_request_size (req_tdata[46:15]),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp              (rsp),
      .map_req          (map_req),
      .map_rd_data      (map_rd_data),
      .eff_total        (eff_total),
      .scan_word        (scan_word),
      .scan_res         (scan_res)
   );

   bfa_scan u_scan (
      .eff_total (eff_total),
      .word_sel  (scan_word),
      .word_data (map_rd_data),
      .result    (scan_res)
   );

   bfa_map #(
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .map_req (map_req),
      .rd_data (map_rd_data)
   );

   assign rsp_tdata = {3'b000, rsp};

endmodule

`default_nettype wire

[rtl/core/bfa_checker.sv]
// Port-level checks of the bitmap frame allocator and their bind to the top.
// Depends on bfa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bfa_checker
   import bfa_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   // a stalled result holds its value
   `BFA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // one item at a time: no new transfer while a result waits
   `BFA_ASSERT(a_one_item, rsp_tvalid, !req_tready)
   `BFA_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // only a good allocate carries an address, only a good free or test a used bit
   `BFA_ASSERT(a_addr_on_fail, rsp_tvalid && (rsp_tdata[1:0] != 2'(ST_OK)), rsp_tdata[44:17] == '0)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);

`default_nettype wire

[bench/frame_alloc_checker.sv]
// Checker for the bitmap frame allocator: watches the csr, req and rsp channels,
// keeps its own copy of the frame map and used count, and compares every response.
// Depends on bfa_pkg for the command and status codes and the response layout.
`default_nettype none

module frame_alloc_checker
   import bfa_pkg::*;
#(
   parameter int unsigned MAX_FRAMES  = MAX_FRAMES_DEF,
   parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   output int               mismatches,
   output int               pending
);

   localparam int unsigned MAP_WORDS = (MAX_FRAMES + 31) / 32;

   typedef struct {
      status_type         status;
      logic [IDX_W-1:0]   frame_number;
      logic [ADDR_W-1:0]  frame_address;
      logic               frame_was_used;
      logic [FRAME_W-1:0] free_frames;
   } alloc_answer_type;

   logic [31:0]        map_model [MAP_WORDS];
   logic [FRAME_W-1:0] used_model;
   logic [FRAME_W-1:0] total_model;
   alloc_answer_type   answers_due [$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   function automatic int unsigned frame_limit();
      return (total_model > MAX_FRAMES) ? MAX_FRAMES : int'(total_model);
   endfunction

   function automatic int unsigned frames_left();
      int unsigned lim;
      lim = frame_limit();
      return (used_model >= lim) ? 0 : lim - used_model;
   endfunction

   function automatic void fill_map();
      for (int unsigned w = 0; w < MAP_WORDS; w++) begin
         map_model[w] = '1;
      end
   endfunction

   // Apply one command to the model and return the response it should produce.
   function automatic alloc_answer_type compute_answer(input cmd_type cmd,
                                                       input logic [IDX_W-1:0] idx,
                                                       input logic [REQ_W-1:0] size);
      alloc_answer_type ans;
      int unsigned      lim;
      int unsigned      w;
      int unsigned      b;
      int unsigned      f;
      longint unsigned  byte_addr;
      bit               found;
      lim                = frame_limit();
      ans.status         = ST_OK;
      ans.frame_number   = '0;
      ans.frame_address  = '0;
      ans.frame_was_used = 1'b0;
      found              = 1'b0;
      case (cmd)
         CMD_ALLOC: begin
            if (frames_left() > size) begin
               for (w = 0; w < (lim + 31) / 32 && !found; w++) begin
                  if (map_model[w] != '1) begin
                     for (b = 0; b < 32 && !found; b++) begin
                        f = w * 32 + b;
                        if (f < lim && !map_model[w][b]) begin
                           map_model[w][b]   = 1'b1;
                           used_model        = used_model + 1'b1;
                           byte_addr         = longint'(f) * FRAME_BYTES;
                           ans.frame_number  = f[IDX_W-1:0];
                           ans.frame_address = byte_addr[ADDR_W-1:0];
                           found             = 1'b1;
                        end
                     end
                  end
               end
            end
            if (!found) ans.status = ST_NOMEM;
         end
         CMD_FREE: begin
            ans.frame_number = idx;
            if (idx >= lim) begin
               ans.status = ST_RANGE;
            end else begin
               ans.frame_was_used         = map_model[idx >> 5][idx[4:0]];
               map_model[idx >> 5][idx[4:0]] = 1'b0;
               // count drops even when the frame was already free
               if (used_model != 0) used_model = used_model - 1'b1;
            end
         end
         CMD_FILL: begin
            fill_map();
         end
         default: begin
            ans.frame_number = idx;
            if (idx >= lim) ans.status = ST_RANGE;
            else ans.frame_was_used = map_model[idx >> 5][idx[4:0]];
         end
      endcase
      ans.free_frames = FRAME_W'(frames_left());
      return ans;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      alloc_answer_type want;
      rsp_type          got;
      if (reset) begin
         fill_map();
         used_model  = '0;
         total_model = TOTAL_RESET;
         answers_due.delete();
      end else begin
         // the response of an item can never leave at the edge that takes it in
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               flag_mismatch("response with nothing outstanding", rsp_tdata[31:0], '0);
            end else begin
               want = answers_due.pop_front();
               got  = rsp_type'(rsp_tdata[60:0]);
               if (got.status !== want.status)
                  flag_mismatch("status", got.status, want.status);
               if (got.frame_number !== want.frame_number)
                  flag_mismatch("frame_number", got.frame_number, want.frame_number);
               if (got.frame_address !== want.frame_address)
                  flag_mismatch("frame_address", got.frame_address, want.frame_address);
               if (got.frame_was_used !== want.frame_was_used)
                  flag_mismatch("frame_was_used", got.frame_was_used, want.frame_was_used);
               if (got.free_frames !== want.free_frames)
                  flag_mismatch("free_frames", got.free_frames, want.free_frames);
               if (rsp_tdata[63:61] !== 3'b000)
                  flag_mismatch("tdata padding", rsp_tdata[63:61], '0);
            end
         end
         if (req_tvalid && req_tready) begin
            answers_due.push_back(compute_answer(cmd_type'(req_tuser), req_tdata[14:0],
                                                 req_tdata[46:15]));
         end
         if (csr_wr_en) total_model = csr_wr_data;
      end
      pending = answers_due.size();
   end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Top of the frame allocator bench: clock, reset, request stimulus, response
// back-pressure, total_frames writes between phases, watchdog and verdict.
// Depends on bfa_pkg, bitmap_frame_allocator and frame_alloc_checker.
`default_nettype none

module tb_top;
   import bfa_pkg::*;

   // the limit sits well above a mark-all-used sweep; stalls add far less
   localparam int QUIET_LIMIT  = 40000;
   localparam int PHASE_ITEMS  = 45;
   localparam int PHASE_COUNT  = 12;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;

   int mismatches;
   int pending;
   int send_idle_pct;
   int rsp_stall_pct;
   int quiet_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   bitmap_frame_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   frame_alloc_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer
   // with tvalid still high, so back-to-back items keep it up.
   task automatic send_request(input cmd_type cmd, input logic [IDX_W-1:0] idx,
                               input logic [REQ_W-1:0] size);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, size, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop tvalid, drain every outstanding response, then write the register.
   task automatic set_total(input logic [15:0] frames);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= frames;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly in-range frames near the bottom of the map so that frees feed the
   // allocations; the rest are anywhere, on the limit edge, or out of range.
   task automatic random_request(input int unsigned lim);
      cmd_type          cmd;
      logic [IDX_W-1:0] idx;
      logic [REQ_W-1:0] size;
      int unsigned      pick;
      int unsigned      window;
      pick = $urandom_range(99, 0);
      if (pick < 36)      cmd = CMD_ALLOC;
      else if (pick < 70) cmd = CMD_FREE;
      else if (pick < 73) cmd = CMD_FILL;
      else                cmd = CMD_TEST;
      window = (lim < 64) ? lim : 64;
      pick   = $urandom_range(99, 0);
      if (lim == 0 || pick < 15) idx = IDX_W'($urandom);
      else if (pick < 25)        idx = IDX_W'(lim - 1 + $urandom_range(1, 0));
      else                       idx = IDX_W'($urandom_range(window - 1, 0));
      pick = $urandom_range(99, 0);
      if (pick < 60)      size = '0;
      else if (pick < 80) size = $urandom_range(lim + 2, 0);
      else if (pick < 92) size = $urandom;
      else                size = '1;
      send_request(cmd, idx, size);
   endtask

   initial begin : stimulus
      logic [15:0] phase_total [PHASE_COUNT];
      int unsigned lim;
      phase_total = '{16'd40, 16'd32768, 16'd1, 16'd0, 16'd33, 16'd65535,
                      16'd32, 16'd200, 16'd31, 16'd2, 16'd100, 16'd0};
      phase_total[PHASE_COUNT-1] = 16'($urandom_range(300, 3));
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = CMD_TEST;
      rsp_tready    = 1'b1;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      quiet_cycles  = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // map starts full: the first allocate scans the whole map and refuses
      send_request(CMD_ALLOC, '0, '0);
      send_request(CMD_TEST, '0, '0);
      send_request(CMD_TEST, '1, '0);
      send_request(CMD_FREE, '1, '0);
      send_request(CMD_FREE, '1, '0);          // already free; the used count is already zero and stays there
      send_request(CMD_ALLOC, '0, '0);         // top frame, largest address
      send_request(CMD_FREE, 15'd5, '0);
      send_request(CMD_FREE, 15'd6, '0);
      send_request(CMD_ALLOC, '0, '1);
      send_request(CMD_ALLOC, '0, 32'd32767);  // free count just above the size
      send_request(CMD_ALLOC, '0, 32'd32767);  // free count equal to the size
      send_request(CMD_FILL, '1, '1);
      send_request(CMD_TEST, 15'd6, '0);
      set_total(16'd0);
      send_request(CMD_ALLOC, '0, '0);
      send_request(CMD_FREE, '0, '0);
      send_request(CMD_TEST, '0, '0);
      set_total(16'd65535);                    // clipped to the map size
      send_request(CMD_TEST, '1, '0);
      send_request(CMD_FREE, 15'd100, '0);
      set_total(16'd33);
      send_request(CMD_FREE, 15'd32, '0);
      send_request(CMD_TEST, 15'd33, '0);
      send_request(CMD_FREE, '1, '0);
      send_request(CMD_ALLOC, '0, '0);
      send_request(CMD_ALLOC, '0, 32'h8000_0000);
      set_total(16'd1);
      send_request(CMD_FREE, '0, '0);
      send_request(CMD_ALLOC, '0, '0);
      send_request(CMD_ALLOC, '0, '0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_total(phase_total[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         lim = (phase_total[p] > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : phase_total[p];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_request(lim);
         end
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/bfa_pkg.sv
rtl/core/bfa_map.sv
rtl/core/bfa_scan.sv
rtl/core/bfa_ctrl.sv
rtl/core/bitmap_frame_allocator.sv
rtl/core/bfa_checker.sv
bench/frame_alloc_checker.sv
bench/tb_top.sv
